// File: rtl/core/cobs_frame_receiver_core_defines.svh
// Assertion macros for the COBS frame receiver core.
// Included by the top level; needs no other file.
`ifndef COBS_FRAME_RECEIVER_CORE_DEFINES_SVH
`define COBS_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CFR_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define CFR_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/cfr_pkg.sv
// Shared types and constants for the COBS frame receiver core.
// No dependencies.
`timescale 1ns / 1ps

package cfr_pkg;

  // Fixed field widths
  localparam int BYTE_W = 8;
  localparam int POS_W  = 7;   // write position / packet length
  localparam int CNT_W  = 7;   // encoded bytes in the frame

  localparam logic [BYTE_W-1:0] DELIM    = 8'h00;
  localparam logic [BYTE_W-1:0] CODE_MAX = 8'hFF;

  // Frame-end handoff from decoder to drain
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] len;
  } cfr_done_t;

endpackage

// File: rtl/core/cobs_frame_receiver_core.sv
// COBS frame receiver top level: decoder, packet store and drain.
// Depends on cfr_pkg, cfr_decode, cfr_store, cfr_drain and the defines header.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_ready   | rx_byte
//  out     | out_valid / out_ready | data_byte, last_byte, empty_packet
//
// A received beat is decoded straight into the store. A good frame's delimiter
// starts a burst of N beats, each a store read, then an output register load
// that waits while the register is full; an empty packet is one zero beat.
// Input stalls during the burst; the last beat may still wait in the output
// register. Reset clears sync and frame state; the store needs no clearing pass.
`timescale 1ns / 1ps
`include "cobs_frame_receiver_core_defines.svh"

module cobs_frame_receiver_core #(
  parameter int PACKET_MAX  = 64,
  parameter int ENCODED_MAX = 66
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cfr_pkg::BYTE_W-1:0] rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cfr_pkg::BYTE_W-1:0] data_byte,
  output logic                       last_byte,
  output logic                       empty_packet
);

  localparam int ADDR_W = (PACKET_MAX > 1) ? $clog2(PACKET_MAX) : 1;

  logic                       acc;
  logic                       idle;
  logic                       we;
  logic [ADDR_W-1:0]          waddr;
  logic [cfr_pkg::BYTE_W-1:0] wdata;
  logic                       re;
  logic [ADDR_W-1:0]          raddr;
  logic [cfr_pkg::BYTE_W-1:0] rdata;
  cfr_pkg::cfr_done_t         done;

  // Hold off input while a burst reads the store
  assign in_ready = idle;
  assign acc      = in_valid && in_ready;

  cfr_decode #(
    .PACKET_MAX  (PACKET_MAX),
    .ENCODED_MAX (ENCODED_MAX),
    .ADDR_W      (ADDR_W)
  ) u_decode (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .rx_byte (rx_byte),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .done    (done)
  );

  cfr_store #(
    .PACKET_MAX (PACKET_MAX),
    .ADDR_W     (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  cfr_drain #(
    .ADDR_W (ADDR_W)
  ) u_drain (
    .clk          (clk),
    .rst          (rst),
    .done         (done),
    .idle         (idle),
    .re           (re),
    .raddr        (raddr),
    .rdata        (rdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .empty_packet (empty_packet)
  );

  // Store writes come only from accepted beats, never during a burst
  `CFR_ASSERT_NOW(a_write_idle, clk, rst, we, acc && idle, "store write outside accepted beat")

  // A handed-off frame blocks input on the next cycle
  `CFR_ASSERT_NEXT(a_done_blocks, clk, rst, done.valid, !in_ready, "input open after frame end")

  // An empty packet is a single zero beat marked last
  `CFR_ASSERT_NOW(a_empty_form, clk, rst, out_valid && empty_packet,
                  last_byte && (data_byte == cfr_pkg::DELIM), "malformed empty packet beat")

endmodule

// File: rtl/core/cfr_store.sv
// Decoded packet store: one write port, one read port, registered read data.
// Depends on cfr_pkg.
`timescale 1ns / 1ps

module cfr_store #(
  parameter int PACKET_MAX = 64,
  parameter int ADDR_W     = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [cfr_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [cfr_pkg::BYTE_W-1:0] rdata
);

  logic [cfr_pkg::BYTE_W-1:0] mem [PACKET_MAX];

  // Write decoded byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds when no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/cfr_decode.sv
// Frame tracker and COBS decoder: sync, group counting, writes into the store.
// Depends on cfr_pkg.
`timescale 1ns / 1ps

module cfr_decode #(
  parameter int PACKET_MAX  = 64,
  parameter int ENCODED_MAX = 66,
  parameter int ADDR_W      = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       acc,
  input  logic [cfr_pkg::BYTE_W-1:0] rx_byte,
  output logic                       we,
  output logic [ADDR_W-1:0]          waddr,
  output logic [cfr_pkg::BYTE_W-1:0] wdata,
  output cfr_pkg::cfr_done_t         done
);

  localparam int PW = cfr_pkg::POS_W;
  localparam int CW = cfr_pkg::CNT_W;
  localparam int BW = cfr_pkg::BYTE_W;
  localparam int XW = cfr_pkg::BYTE_W + 1;
  localparam logic [PW-1:0] PKT_LIM = PW'(PACKET_MAX);
  localparam logic [CW-1:0] ENC_LIM = CW'(ENCODED_MAX);

  logic          synced, synced_next;
  logic [CW-1:0] frame_count, frame_count_next;
  logic [PW-1:0] write_pos, write_pos_next;
  logic [BW-1:0] group_remaining, group_remaining_next;
  logic          zero_pending, zero_pending_next;
  logic          frame_bad, frame_bad_next;

  logic [PW-1:0] pos_after_zero;
  logic [XW-1:0] group_len;
  logic [XW-1:0] room;

  assign group_len = XW'(rx_byte) - XW'(1);

  // Decode one accepted beat
  always_comb begin
    synced_next          = synced;
    frame_count_next     = frame_count;
    write_pos_next       = write_pos;
    group_remaining_next = group_remaining;
    zero_pending_next    = zero_pending;
    frame_bad_next       = frame_bad;
    we                   = 1'b0;
    waddr                = write_pos[ADDR_W-1:0];
    wdata                = rx_byte;
    done.valid           = 1'b0;
    done.len             = write_pos;
    pos_after_zero       = write_pos;
    room                 = XW'(PKT_LIM) - XW'(write_pos);

    if (acc) begin
      if (!synced) begin
        // Hunt for a delimiter
        synced_next = (rx_byte == cfr_pkg::DELIM);
      end else if (rx_byte == cfr_pkg::DELIM) begin
        // Close the frame; hand a good one to the drain
        done.valid = (frame_count != '0) && !frame_bad && (group_remaining == '0);
        frame_count_next     = '0;
        write_pos_next       = '0;
        group_remaining_next = '0;
        zero_pending_next    = 1'b0;
        frame_bad_next       = 1'b0;
      end else if (frame_count >= ENC_LIM) begin
        // Frame too long: drop state and lose sync
        synced_next          = 1'b0;
        frame_count_next     = '0;
        write_pos_next       = '0;
        group_remaining_next = '0;
        zero_pending_next    = 1'b0;
        frame_bad_next       = 1'b0;
      end else begin
        frame_count_next = frame_count + CW'(1);
        if (!frame_bad) begin
          if (group_remaining == '0) begin
            // Code byte: flush pending zero, then open the next group
            if (zero_pending && (write_pos >= PKT_LIM)) begin
              frame_bad_next = 1'b1;
            end else begin
              if (zero_pending) begin
                we             = 1'b1;
                wdata          = cfr_pkg::DELIM;
                pos_after_zero = write_pos + PW'(1);
              end
              write_pos_next = pos_after_zero;
              room           = XW'(PKT_LIM) - XW'(pos_after_zero);
              if (group_len > room) begin
                frame_bad_next = 1'b1;
              end else begin
                group_remaining_next = group_len[BW-1:0];
                zero_pending_next    = (rx_byte != cfr_pkg::CODE_MAX);
              end
            end
          end else begin
            // Data byte
            if (write_pos < PKT_LIM) begin
              we             = 1'b1;
              write_pos_next = write_pos + PW'(1);
            end else begin
              frame_bad_next = 1'b1;
            end
            group_remaining_next = group_remaining - BW'(1);
          end
        end
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      synced          <= 1'b0;
      frame_count     <= '0;
      write_pos       <= '0;
      group_remaining <= '0;
      zero_pending    <= 1'b0;
      frame_bad       <= 1'b0;
    end else begin
      synced          <= synced_next;
      frame_count     <= frame_count_next;
      write_pos       <= write_pos_next;
      group_remaining <= group_remaining_next;
      zero_pending    <= zero_pending_next;
      frame_bad       <= frame_bad_next;
    end
  end

endmodule

// File: rtl/core/cfr_drain.sv
// Packet drain: reads the store in order and drives the output register.
// Depends on cfr_pkg.
`timescale 1ns / 1ps

module cfr_drain #(
  parameter int ADDR_W = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfr_pkg::cfr_done_t         done,
  output logic                       idle,
  output logic                       re,
  output logic [ADDR_W-1:0]          raddr,
  input  logic [cfr_pkg::BYTE_W-1:0] rdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cfr_pkg::BYTE_W-1:0] data_byte,
  output logic                       last_byte,
  output logic                       empty_packet
);

  localparam int PW = cfr_pkg::POS_W;

  typedef enum logic [1:0] {
    D_IDLE,
    D_READ,
    D_LOAD,
    D_EMPTY
  } dstate_t;

  dstate_t           dstate;
  logic [ADDR_W-1:0] rd_ptr;
  logic [PW-1:0]     len;
  logic              slot_free;
  logic              at_end;
  logic              load;

  assign slot_free = !out_valid || out_ready;
  assign at_end    = (PW'(rd_ptr) + PW'(1)) == len;
  assign idle      = (dstate == D_IDLE);
  assign re        = (dstate == D_READ);
  assign raddr     = rd_ptr;
  assign load      = slot_free && ((dstate == D_LOAD) || (dstate == D_EMPTY));

  // Sequence reads and output beats
  always_ff @(posedge clk) begin
    if (rst) begin
      dstate    <= D_IDLE;
      rd_ptr    <= '0;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Fill the output register, or free it once its beat is taken
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (dstate)
        D_IDLE: begin
          if (done.valid) begin
            rd_ptr <= '0;
            len    <= done.len;
            dstate <= (done.len == '0) ? D_EMPTY : D_READ;
          end
        end
        D_READ: begin
          dstate <= D_LOAD;
        end
        D_LOAD: begin
          if (slot_free) begin
            data_byte    <= rdata;
            last_byte    <= at_end;
            empty_packet <= 1'b0;
            if (at_end) begin
              dstate <= D_IDLE;
            end else begin
              rd_ptr <= rd_ptr + ADDR_W'(1);
              dstate <= D_READ;
            end
          end
        end
        D_EMPTY: begin
          if (slot_free) begin
            data_byte    <= cfr_pkg::DELIM;
            last_byte    <= 1'b1;
            empty_packet <= 1'b1;
            dstate       <= D_IDLE;
          end
        end
        default: begin
          dstate <= D_IDLE;
        end
      endcase
    end
  end

endmodule
